// ===== design/mfvm_pkg.sv =====
// Shared types and constants for the masked four-vector mass block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mfvm_pkg;

    // Fixed field widths
    localparam int IN_W       = 24;   // loaded component width
    localparam int SLOT_W     = 4;
    localparam int MASK_W     = 16;
    localparam int MASK_IDX_W = 4;    // index into the selection mask
    localparam int SUM_W      = 28;   // component sum width
    localparam int ROOT_W     = 28;   // mass width
    localparam int SQ_W       = 2 * SUM_W;  // squared magnitudes and their sums
    localparam int REM_W      = ROOT_W + 3; // square root remainder
    localparam int STEP_W     = $clog2(ROOT_W);
    localparam int NUM_COMP   = 4;

    // Component order inside a vector
    localparam int COMP_PX     = 0;
    localparam int COMP_PY     = 1;
    localparam int COMP_PZ     = 2;
    localparam int COMP_ENERGY = 3;

    // Stream word widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 144;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                           kind;
        logic [SLOT_W-1:0]               slot;
        logic [NUM_COMP-1:0][IN_W-1:0]   comp;
        logic [MASK_W-1:0]               mask;
    } item_t;

    // Result word, last member in the lowest bits
    typedef struct packed {
        logic [ROOT_W-1:0] mass;
        logic [SUM_W-1:0]  energy;
        logic [SUM_W-1:0]  pz;
        logic [SUM_W-1:0]  py;
        logic [SUM_W-1:0]  px;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SQUARE,
        ST_DIFF,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== design/mfvm_front.sv =====
// Front end: unpacks input words, classifies them and pushes work to the queue.
// Uses mfvm_pkg for the item layout.
`default_nettype none

module mfvm_front #(
    parameter int VECTOR_COUNT = 16
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // slot, load_px, load_py, load_pz, load_energy, select_mask, zero pad
    input  wire logic [mfvm_pkg::IN_TDATA_W-1:0] s_tdata,
    // action
    input  wire logic                          s_tuser,
    input  wire logic                          q_full,
    output logic                               q_push,
    output mfvm_pkg::item_t                    q_item
);

    logic accept;
    logic slot_ok;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & ~q_full;

    // Unpack the word
    always_comb begin
        q_item.kind = (s_tuser) ? mfvm_pkg::KIND_QUERY : mfvm_pkg::KIND_LOAD;
        q_item.slot = s_tdata[mfvm_pkg::SLOT_W-1:0];
        for (int k = 0; k < mfvm_pkg::NUM_COMP; k++) begin
            q_item.comp[k] = s_tdata[mfvm_pkg::SLOT_W + k*mfvm_pkg::IN_W +: mfvm_pkg::IN_W];
        end
        q_item.mask = s_tdata[mfvm_pkg::SLOT_W + mfvm_pkg::NUM_COMP*mfvm_pkg::IN_W
                              +: mfvm_pkg::MASK_W];
    end

    // Loads outside the table are dropped here; they never reach the back end
    assign slot_ok = (32'(q_item.slot) < VECTOR_COUNT);
    assign q_push  = accept & (s_tuser | slot_ok);

endmodule

`default_nettype wire

// ===== design/mfvm_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
// Uses mfvm_pkg for the item type and depth constants.
`default_nettype none

module mfvm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mfvm_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output mfvm_pkg::item_t      pop_item,
    output logic                 empty
);

    mfvm_pkg::item_t                entry_reg [mfvm_pkg::QUEUE_DEPTH];
    logic [mfvm_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mfvm_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mfvm_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign full     = (count_reg == mfvm_pkg::QCNT_W'(mfvm_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + mfvm_pkg::QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + mfvm_pkg::QPTR_W'(do_pop);
        count_next  = count_reg + mfvm_pkg::QCNT_W'(do_push) - mfvm_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/mfvm_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Uses mfvm_pkg for the radicand and root widths.
`default_nettype none

module mfvm_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [mfvm_pkg::SQ_W-1:0] radicand,
    output logic                           done,
    output logic [mfvm_pkg::ROOT_W-1:0]    root
);

    localparam int TR_W = mfvm_pkg::REM_W + 2;

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [mfvm_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [mfvm_pkg::SQ_W-1:0]        rad_reg, rad_next;
    logic [mfvm_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [mfvm_pkg::ROOT_W-1:0]      root_reg, root_next;
    logic [TR_W-1:0]                  cand, trial, dif;
    logic                             fits;

    // One restoring step: bring in two radicand bits, try 4r+1
    assign cand  = {rem_reg, rad_reg[mfvm_pkg::SQ_W-1 -: 2]};
    assign trial = TR_W'({root_reg, 2'b01});
    assign fits  = (cand >= trial);
    assign dif   = cand - trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? mfvm_pkg::REM_W'(dif) : mfvm_pkg::REM_W'(cand);
            root_next = {root_reg[mfvm_pkg::ROOT_W-2:0], fits};
            rad_next  = rad_reg << 2;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == mfvm_pkg::STEP_W'(mfvm_pkg::ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== design/mfvm_back.sv =====
// Back end: vector table, masked summation, squaring, square root and result register.
// Uses mfvm_pkg and instantiates mfvm_sqrt.
`default_nettype none

module mfvm_back #(
    parameter int VECTOR_COUNT   = 16,
    parameter int COMPONENT_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire mfvm_pkg::item_t                 q_item,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mfvm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int IDX_W = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
    localparam int WALK  = (VECTOR_COUNT < mfvm_pkg::MASK_W) ? VECTOR_COUNT
                                                             : mfvm_pkg::MASK_W;
    localparam int CNT_W = $clog2(WALK + 1);

    typedef logic [mfvm_pkg::NUM_COMP-1:0][COMPONENT_BITS-1:0] row_t;

    // Vector table: one row per slot, valid bits cleared by reset
    row_t                               mem [VECTOR_COUNT];
    logic [VECTOR_COUNT-1:0]            vld_reg, vld_next;
    row_t                               rdata_reg;
    row_t                               wrow;
    logic [IDX_W-1:0]                   waddr, raddr;
    logic                               mem_we, rd_en;

    mfvm_pkg::state_t                   state_reg, state_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [mfvm_pkg::MASK_W-1:0]        mask_reg, mask_next;
    logic                               rsel_reg, rsel_next;
    logic [mfvm_pkg::NUM_COMP-1:0][mfvm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [2:0]                         sq_cnt_reg, sq_cnt_next;
    logic [mfvm_pkg::SQ_W-1:0]          prod_reg, prod_next;
    logic [mfvm_pkg::SQ_W-1:0]          e2_reg, e2_next;
    logic [mfvm_pkg::SQ_W-1:0]          p2_reg, p2_next;
    mfvm_pkg::res_t                     out_reg, out_next;
    logic                               m_tvalid_reg, m_tvalid_next;

    logic [mfvm_pkg::SUM_W-1:0]         op_sum, op_mag;
    logic [mfvm_pkg::SQ_W-1:0]          sq_full;
    logic [mfvm_pkg::SQ_W-1:0]          diff;
    logic                               sqrt_start, sqrt_done;
    logic [mfvm_pkg::ROOT_W-1:0]        sqrt_root;

    // Narrow or widen loaded components to the table width
    always_comb begin
        for (int k = 0; k < mfvm_pkg::NUM_COMP; k++) begin
            wrow[k] = COMPONENT_BITS'(signed'(q_item.comp[k]));
        end
    end

    assign waddr = IDX_W'(q_item.slot);
    assign raddr = IDX_W'(cnt_reg);

    // Shared squarer: magnitude of one sum per cycle
    assign op_sum  = sum_reg[sq_cnt_reg[1:0]];
    assign op_mag  = op_sum[mfvm_pkg::SUM_W-1] ? (~op_sum + 1'b1) : op_sum;
    assign sq_full = op_mag * op_mag;

    assign diff = (e2_reg >= p2_reg) ? (e2_reg - p2_reg) : (p2_reg - e2_reg);

    mfvm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (diff),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Sequencer: next state and datapath control
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        rsel_next     = 1'b0;
        sum_next      = sum_reg;
        sq_cnt_next   = sq_cnt_reg;
        prod_next     = prod_reg;
        e2_next       = e2_reg;
        p2_next       = p2_reg;
        out_next      = out_reg;
        vld_next      = vld_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        sqrt_start    = 1'b0;

        case (state_reg)
            mfvm_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_item.kind == mfvm_pkg::KIND_LOAD) begin
                        mem_we          = 1'b1;
                        vld_next[waddr] = 1'b1;
                    end else begin
                        mask_next  = q_item.mask;
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = mfvm_pkg::ST_WALK;
                    end
                end
            end
            mfvm_pkg::ST_WALK: begin
                // add the row read last cycle, issue the next read
                if (rsel_reg) begin
                    for (int k = 0; k < mfvm_pkg::NUM_COMP; k++) begin
                        sum_next[k] = sum_reg[k]
                                    + mfvm_pkg::SUM_W'(signed'(rdata_reg[k]));
                    end
                end
                if (cnt_reg == CNT_W'(WALK)) begin
                    sq_cnt_next = '0;
                    p2_next     = '0;
                    state_next  = mfvm_pkg::ST_SQUARE;
                end else begin
                    rd_en     = 1'b1;
                    rsel_next = mask_reg[mfvm_pkg::MASK_IDX_W'(cnt_reg)] & vld_reg[raddr];
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            mfvm_pkg::ST_SQUARE: begin
                // square sums 0..3 in turn; each registered product is added to p2, or kept as e2, in the next cycle
                if (sq_cnt_reg != 3'(mfvm_pkg::NUM_COMP)) begin
                    prod_next = sq_full;
                end
                if (sq_cnt_reg == 3'(mfvm_pkg::COMP_ENERGY + 1)) begin
                    e2_next    = prod_reg;
                    state_next = mfvm_pkg::ST_DIFF;
                end else if (sq_cnt_reg != '0) begin
                    p2_next = p2_reg + prod_reg;
                end
                sq_cnt_next = sq_cnt_reg + 1'b1;
            end
            mfvm_pkg::ST_DIFF: begin
                sqrt_start = 1'b1;
                state_next = mfvm_pkg::ST_ROOT;
            end
            mfvm_pkg::ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = mfvm_pkg::ST_OUT;
                end
            end
            mfvm_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next.px     = sum_reg[mfvm_pkg::COMP_PX];
                    out_next.py     = sum_reg[mfvm_pkg::COMP_PY];
                    out_next.pz     = sum_reg[mfvm_pkg::COMP_PZ];
                    out_next.energy = sum_reg[mfvm_pkg::COMP_ENERGY];
                    out_next.mass   = sqrt_root;
                    m_tvalid_next   = 1'b1;
                    state_next      = mfvm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfvm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mfvm_pkg::ST_IDLE;
            vld_reg      <= '0;
            rsel_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            sq_cnt_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            rsel_reg     <= rsel_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            sq_cnt_reg   <= sq_cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        e2_reg   <= e2_next;
        p2_reg   <= p2_next;
        out_reg  <= out_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wrow;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mfvm_pkg::OUT_TDATA_W'(out_reg);

endmodule

`default_nettype wire

// ===== design/masked_four_vector_mass.sv =====
// Masked four-vector mass: a table of VECTOR_COUNT four-vectors (px, py, pz, energy)
// loaded one slot per word; a query word sums the slots picked by its mask and returns
// the four sums plus floor(sqrt(|E^2 - p^2|)). Slots never loaded read as zero vectors,
// loads to slots beyond the table are dropped, and mask bits beyond the table are
// ignored. A two-entry queue sits between the input side and the compute side, and
// the result sits in an output register, so new words keep coming in while a result
// waits. A load is written to the table as it is taken from the queue. A query is
// taken from the queue, reads each table slot in turn through the registered read
// port of the table memory, squares the four sums on the shared squarer, starts the
// root, runs 28 bit-serial root steps, hands the root back and goes into the output
// register when that register is free. Queries run one at a time.
// Depends on mfvm_pkg, mfvm_front, mfvm_queue, mfvm_back.
`default_nettype none

module masked_four_vector_mass #(
    parameter int VECTOR_COUNT   = 16,
    parameter int COMPONENT_BITS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // slot[3:0], load_px[27:4], load_py[51:28], load_pz[75:52],
    // load_energy[99:76], select_mask[115:100], zero pad
    input  wire logic [mfvm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // sum_px[27:0], sum_py[55:28], sum_pz[83:56], sum_energy[111:84],
    // mass[139:112], zero pad
    output logic [mfvm_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    logic            q_full, q_push, q_pop, q_empty;
    mfvm_pkg::item_t push_item, pop_item;

    mfvm_front #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    mfvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    mfvm_back #(
        .VECTOR_COUNT   (VECTOR_COUNT),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
